[hw/rtl/stack_track_reorder_macros.svh]
// ----------------------------------------------------------------------------
// stack_track_reorder assertion macros
// Shared property wrappers for the reorder block checks.
// ----------------------------------------------------------------------------
`ifndef STACK_TRACK_REORDER_MACROS_SVH
`define STACK_TRACK_REORDER_MACROS_SVH

// same-cycle implication, disabled in reset
`define STR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define STR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/str_pkg.sv]
// ----------------------------------------------------------------------------
// str_pkg
// Types, sizes and helpers shared by the holding-track reorder block.
// ----------------------------------------------------------------------------
package str_pkg;

   localparam int NUM_TRACKS  = 4;
   localparam int TRACK_DEPTH = 8;
   localparam int CAR_BITS    = 8;

   localparam int SLOTS  = NUM_TRACKS * TRACK_DEPTH;
   localparam int TRK_W  = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
   localparam int CNT_W  = $clog2(NUM_TRACKS + 1);
   localparam int FILL_W = $clog2(TRACK_DEPTH + 1);
   localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef logic [CAR_BITS-1:0] car_type;
   typedef logic [TRK_W-1:0]    trk_type;
   typedef logic [CNT_W-1:0]    cnt_type;
   typedef logic [FILL_W-1:0]   fill_type;
   typedef logic [ADDR_W-1:0]   addr_type;

   typedef enum logic [1:0] {
      ACT_DIRECT   = 2'd0,
      ACT_POP      = 2'd1,
      ACT_PUSH     = 2'd2,
      ACT_OVERFLOW = 2'd3
   } action_type;

   typedef struct packed {
      action_type action;
      logic [7:0] moved_car;
      logic [2:0] track_index;
      logic [3:0] tracks_used;
      logic       last_of_run;
   } result_type;

   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      car_type  wr_data;
      logic     rd_en;
      addr_type rd_addr;
   } mem_req_type;

   function automatic addr_type slot_addr(input trk_type trk, input fill_type slot);
      int a;
      a = int'(trk) * TRACK_DEPTH + int'(slot);
      return ADDR_W'(a);
   endfunction

endpackage

[hw/rtl/str_ram.sv]
// ----------------------------------------------------------------------------
// str_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module str_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/str_out_reg.sv]
// ----------------------------------------------------------------------------
// str_out_reg
// Result output register between the sequencer and the response channel.
// ----------------------------------------------------------------------------
module str_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  str_pkg::result_type load_data,
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_action,
   output logic [7:0]          rsp_moved_car,
   output logic [2:0]          rsp_track_index,
   output logic [3:0]          rsp_tracks_used,
   output logic                rsp_last_of_run
);

   logic                valid_ff;
   logic                valid_in;
   str_pkg::result_type data_ff;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_action      = data_ff.action;
   assign rsp_moved_car   = data_ff.moved_car;
   assign rsp_track_index = data_ff.track_index;
   assign rsp_tracks_used = data_ff.tracks_used;
   assign rsp_last_of_run = data_ff.last_of_run;

endmodule

[hw/rtl/str_seq.sv]
// ----------------------------------------------------------------------------
// str_seq
// Track sequencer: push, overflow reject, direct release and pop cascade over the track RAM.
// ----------------------------------------------------------------------------
module str_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_car_number,
   output str_pkg::mem_req_type mem_req,
   input  str_pkg::car_type     mem_rd_data,
   input  logic                 out_free,
   output logic                 emit_valid,
   output str_pkg::result_type  emit_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_REFILL = 4'b0100,
      ST_FLUSH  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   str_pkg::cnt_type    scan_ff, scan_in;
   logic                moved_ff, moved_in;
   str_pkg::fill_type   fill_ff [str_pkg::NUM_TRACKS];
   str_pkg::fill_type   fill_in [str_pkg::NUM_TRACKS];
   str_pkg::car_type    top_ff  [str_pkg::NUM_TRACKS];
   str_pkg::car_type    top_in  [str_pkg::NUM_TRACKS];
   str_pkg::car_type    nem1_ff, nem1_in;
   str_pkg::cnt_type    opened_ff, opened_in;
   str_pkg::result_type pend_ff, pend_in;

   str_pkg::car_type    car;
   str_pkg::car_type    expect_car;
   str_pkg::trk_type    idx;
   logic                fit_found;
   str_pkg::trk_type    fit_trk;
   str_pkg::trk_type    push_trk;
   logic                push_ok;
   logic                push_new;

   assign car        = str_pkg::CAR_BITS'(req_car_number);
   assign expect_car = nem1_ff + str_pkg::car_type'(1);
   assign idx        = scan_ff[str_pkg::TRK_W-1:0];
   assign req_ready  = (state_ff == ST_IDLE);

   always_comb begin
      fit_found = 1'b0;
      fit_trk   = '0;
      for (int t = str_pkg::NUM_TRACKS - 1; t >= 0; t--) begin
         if ((str_pkg::CNT_W'(t) < opened_ff) &&
             (fill_ff[t] < str_pkg::FILL_W'(str_pkg::TRACK_DEPTH)) &&
             ((fill_ff[t] == '0) || (top_ff[t] > car))) begin
            fit_found = 1'b1;
            fit_trk   = str_pkg::TRK_W'(t);
         end
      end
      push_new = !fit_found && (opened_ff < str_pkg::CNT_W'(str_pkg::NUM_TRACKS));
      push_ok  = fit_found || push_new;
      push_trk = fit_found ? fit_trk : opened_ff[str_pkg::TRK_W-1:0];
   end

   always_comb begin
      state_in   = state_ff;
      scan_in    = scan_ff;
      moved_in   = moved_ff;
      fill_in    = fill_ff;
      top_in     = top_ff;
      nem1_in    = nem1_ff;
      opened_in  = opened_ff;
      pend_in    = pend_ff;
      emit_valid = 1'b0;
      emit_data  = pend_ff;
      mem_req    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pend_in.moved_car   = 8'(car);
               pend_in.last_of_run = 1'b0;
               if (car == expect_car) begin
                  pend_in.action      = str_pkg::ACT_DIRECT;
                  pend_in.track_index = '0;
                  pend_in.tracks_used = 4'(opened_ff);
                  nem1_in  = car;
                  scan_in  = '0;
                  moved_in = 1'b0;
                  state_in = ST_SCAN;
               end else if (push_ok) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = str_pkg::slot_addr(push_trk, fill_ff[push_trk]);
                  mem_req.wr_data = car;
                  fill_in[push_trk] = fill_ff[push_trk] + str_pkg::fill_type'(1);
                  top_in[push_trk]  = car;
                  if (push_new) begin
                     opened_in = opened_ff + str_pkg::cnt_type'(1);
                  end
                  pend_in.action      = str_pkg::ACT_PUSH;
                  pend_in.track_index = 3'(push_trk);
                  pend_in.tracks_used = 4'(opened_in);
                  state_in = ST_FLUSH;
               end else begin
                  pend_in.action      = str_pkg::ACT_OVERFLOW;
                  pend_in.track_index = '0;
                  pend_in.tracks_used = 4'(opened_ff);
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_SCAN: begin
            if (scan_ff >= opened_ff) begin
               if (moved_ff) begin
                  scan_in  = '0;
                  moved_in = 1'b0;
               end else begin
                  state_in = ST_FLUSH;
               end
            end else if ((fill_ff[idx] != '0) && (top_ff[idx] == expect_car)) begin
               if (out_free) begin
                  emit_valid = 1'b1;
                  pend_in.action      = str_pkg::ACT_POP;
                  pend_in.moved_car   = 8'(top_ff[idx]);
                  pend_in.track_index = 3'(idx);
                  pend_in.tracks_used = 4'(opened_ff);
                  pend_in.last_of_run = 1'b0;
                  fill_in[idx] = fill_ff[idx] - str_pkg::fill_type'(1);
                  nem1_in  = expect_car;
                  moved_in = 1'b1;
                  if (fill_ff[idx] != str_pkg::fill_type'(1)) begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = str_pkg::slot_addr(idx,
                        fill_ff[idx] - str_pkg::fill_type'(2));
                     state_in = ST_REFILL;
                  end
               end
            end else begin
               scan_in = scan_ff + str_pkg::cnt_type'(1);
            end
         end
         ST_REFILL: begin
            top_in[idx] = mem_rd_data;
            state_in    = ST_SCAN;
         end
         ST_FLUSH: begin
            if (out_free) begin
               emit_valid            = 1'b1;
               emit_data.last_of_run = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         scan_ff   <= '0;
         moved_ff  <= 1'b0;
         nem1_ff   <= '0;
         opened_ff <= '0;
         for (int t = 0; t < str_pkg::NUM_TRACKS; t++) begin
            fill_ff[t] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         scan_ff   <= scan_in;
         moved_ff  <= moved_in;
         nem1_ff   <= nem1_in;
         opened_ff <= opened_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff  <= top_in;
      pend_ff <= pend_in;
   end

endmodule

[hw/rtl/stack_track_reorder.sv]
// ----------------------------------------------------------------------------
// stack_track_reorder
// Railroad car reorder through a bank of LIFO holding tracks.
// ----------------------------------------------------------------------------
// Cars enter on the req_ channel (valid/ready), one car number per transaction.
// Moves leave on the rsp_ channel (valid/ready), one transaction per move;
// rsp_last_of_run marks the final move caused by a car.
// A pushed or rejected car is taken in the idle state and its move waits in the
// flush state until the output register is free, then is loaded into it;
// rsp_valid rises once that register holds the move.
// A direct release walks the opened track tops, one track per cycle while no
// pop waits for the output register, and repeats the walk while it pops
// anything; each pop that leaves the track non-empty adds a refill state for
// the track RAM read of the new top; the flush state sends the final move.
// req_ready is high only while no car is in work; the next car may enter while
// the final move still waits in the output register.
// A stalled receiver holds the sequencer at its next move; nothing is dropped.
// Reset empties all tracks, closes them and sets the expected car to 1; the
// track RAM needs no clearing pass.
// ----------------------------------------------------------------------------
`include "stack_track_reorder_macros.svh"

module stack_track_reorder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_car_number,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_action,
   output logic [7:0] rsp_moved_car,
   output logic [2:0] rsp_track_index,
   output logic [3:0] rsp_tracks_used,
   output logic       rsp_last_of_run
);

   str_pkg::mem_req_type mem_req;
   str_pkg::car_type     mem_rd_data;
   logic                 out_free;
   logic                 emit_valid;
   str_pkg::result_type  emit_data;
   logic                 req_fire;
   logic                 last_emit;

   str_ram #(
      .WIDTH (str_pkg::CAR_BITS),
      .DEPTH (str_pkg::SLOTS)
   ) u_track_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

   str_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_car_number (req_car_number),
      .mem_req        (mem_req),
      .mem_rd_data    (mem_rd_data),
      .out_free       (out_free),
      .emit_valid     (emit_valid),
      .emit_data      (emit_data)
   );

   str_out_reg u_out (
      .clock           (clock),
      .reset           (reset),
      .load            (emit_valid),
      .load_data       (emit_data),
      .free            (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_action      (rsp_action),
      .rsp_moved_car   (rsp_moved_car),
      .rsp_track_index (rsp_track_index),
      .rsp_tracks_used (rsp_tracks_used),
      .rsp_last_of_run (rsp_last_of_run)
   );

   assign req_fire  = req_valid && req_ready;
   assign last_emit = emit_valid && emit_data.last_of_run;

   `STR_ASSERT_NOW(a_no_overwrite, clock, reset, emit_valid, out_free, "result overwritten")
   `STR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_ready, "accept while busy")
   `STR_ASSERT_NOW(a_ram_one_port, clock, reset, mem_req.rd_en, !mem_req.wr_en, "RAM port clash")
   `STR_ASSERT_NOW(a_idle_flush_done, clock, reset, last_emit, !req_ready, "final move in idle")

endmodule
